/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int DEFAULT_KEY_BITS = 32;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] key;
   } spq_req_type;

   typedef struct packed {
      logic               ok;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } spq_rsp_type;

   // Broadcast to every cell in the chain.
   typedef struct packed {
      logic ins;
      logic pop;
   } spq_ctl_type;

endpackage

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares the broadcast key against its own
// and takes the new key, its left neighbor's key or its right neighbor's key.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int KEY_BITS = spq_pkg::DEFAULT_KEY_BITS
) (
   input  logic                clock,
   input  spq_pkg::spq_ctl_type ctl,
   input  logic [KEY_BITS-1:0] ins_key,
   input  logic                slot_valid,
   input  logic                left_lt,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [KEY_BITS-1:0] right_key,
   output logic                lt,
   output logic [KEY_BITS-1:0] key
);

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;

   // Stored keys are ascending, so lt is true for a prefix of the chain.
   assign lt = slot_valid && (key_ff < ins_key);

   always_comb begin
      key_in = key_ff;
      if (ctl.ins && !lt) begin
         // first cell not below the key takes it; cells after it shift right
         key_in = left_lt ? ins_key : left_key;
      end else if (ctl.pop) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle. Every cell compares its key with the
// incoming key and shifts or loads in the same cycle, so an insert or a pop
// finishes in the cycle it is accepted and its result beat appears on the
// next cycle from an output register. The input stalls only while that
// register holds a beat and the result side stalls. Inserts into a full
// queue and pops from an empty one return ok low, value zero and leave the
// contents unchanged. Equal keys are ordered newest first.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY,
   parameter int KEY_BITS = spq_pkg::DEFAULT_KEY_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spq_pkg::spq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output spq_pkg::spq_rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   spq_pkg::spq_rsp_type rsp_ff;
   spq_pkg::spq_rsp_type rsp_in;

   logic                 accept;
   logic                 full;
   logic                 empty;
   logic                 ins_ok;
   logic                 pop_ok;
   spq_pkg::spq_ctl_type ctl;
   logic [KEY_BITS-1:0]  ins_key;

   logic [KEY_BITS-1:0]  cell_key [CAPACITY];
   logic                 cell_lt  [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign ins_ok  = accept && (req_data.kind == spq_pkg::KIND_INSERT) && !full;
   assign pop_ok  = accept && (req_data.kind == spq_pkg::KIND_POP) && !empty;
   assign ins_key = KEY_BITS'(req_data.key);

   always_comb begin
      ctl.ins = ins_ok;
      ctl.pop = pop_ok;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                left_lt;
      logic [KEY_BITS-1:0] left_key;
      logic [KEY_BITS-1:0] right_key;

      if (i == 0) begin : g_head
         assign left_lt  = 1'b1;
         assign left_key = ins_key;
      end else begin : g_body
         assign left_lt  = cell_lt[i-1];
         assign left_key = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_key = cell_key[i];
      end else begin : g_mid
         assign right_key = cell_key[i+1];
      end

      spq_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .ins_key    (ins_key),
         .slot_valid (count_ff > CW'(i)),
         .left_lt    (left_lt),
         .left_key   (left_key),
         .right_key  (right_key),
         .lt         (cell_lt[i]),
         .key        (cell_key[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + CW'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in.ok    = ins_ok || pop_ok;
         rsp_in.value = pop_ok ? spq_pkg::VALUE_W'(cell_key[0]) : '0;
         rsp_in.count = spq_pkg::COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("occupancy above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ins_ok |=> count_ff == $past(count_ff) + CW'(1))
      else $error("stored insert did not grow occupancy");

   a_beat_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_ff.count == spq_pkg::COUNT_W'(count_ff))
      else $error("accepted beat produced no matching result");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.ok |-> rsp_ff.value == '0)
      else $error("failed result carries a value");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(2) |-> cell_key[0] <= cell_key[1])
      else $error("head of chain out of order");
`endif

endmodule

/* verif/sorted_priority_queue_tb.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. A tracker keeps its own
// ascending list of keys, predicts the result beat of every accepted request
// and compares each result beat field by field against it. A short directed
// part fills the queue, overfills it and pops from empty. Random phases then
// lean toward inserts, toward pops or neither, so the queue swings between
// full and empty, while requests idle and results stall at random.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = spq_pkg::DEFAULT_CAPACITY;
   localparam int MAX_REPORT   = 10;
   localparam int RANDOM_ITEMS = 680;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   spq_pkg::spq_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   spq_pkg::spq_rsp_type rsp_data;

   class key_order_tracker;
      logic [spq_pkg::KEY_W-1:0] held_keys[$];
      spq_pkg::spq_rsp_type      awaited[$];
      int                        mismatches;

      function void note_request(spq_pkg::spq_req_type r);
         spq_pkg::spq_rsp_type want;
         int                   pos;
         want = '0;
         if (r.kind == spq_pkg::KIND_INSERT) begin
            if (held_keys.size() < CAPACITY) begin
               // new key goes ahead of the first key that is not smaller
               pos = 0;
               while (pos < held_keys.size() && held_keys[pos] < r.key)
                  pos++;
               held_keys.insert(pos, r.key);
               want.ok = 1'b1;
            end
         end else if (held_keys.size() > 0) begin
            want.value = held_keys.pop_front();
            want.ok    = 1'b1;
         end
         want.count = spq_pkg::COUNT_W'(held_keys.size());
         awaited.push_back(want);
      endfunction

      function void check_result(spq_pkg::spq_rsp_type got);
         spq_pkg::spq_rsp_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
               $display("%0t: result beat with nothing outstanding: %s%b value=%h count=%0d",
                        $time, "ok=", got.ok, got.value, got.count);
            return;
         end
         want = awaited.pop_front();
         if (got.ok !== want.ok || got.value !== want.value || got.count !== want.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
               $display({"%0t: mismatch: expected ok=%b value=%h count=%0d, ",
                         "got ok=%b value=%h count=%0d"},
                        $time, want.ok, want.value, want.count,
                        got.ok, got.value, got.count);
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   key_order_tracker tracker;

   sorted_priority_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // favor extremes and a narrow range so equal keys show up often
   function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return spq_pkg::KEY_W'($urandom_range(0, 7));
         default: return spq_pkg::KEY_W'($urandom);
      endcase
   endfunction

   task automatic send_request(input logic kind, input logic [spq_pkg::KEY_W-1:0] key);
      spq_pkg::spq_req_type r;
      r.kind = kind;
      r.key  = key;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      tracker.note_request(r);
   endtask

   task automatic idle_requests(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      if (tracker.outstanding() != 0) begin
         req_valid <= 1'b0;
         while (tracker.outstanding() != 0)
            @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_data);
   end

   // result side: free runs, sometimes long ones, broken by stalls
   initial begin
      int free_run;
      int hold_run;
      forever begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 5) == 0)
            free_run = $urandom_range(50, 150);
         else
            free_run = $urandom_range(1, 8);
         repeat (free_run) @(posedge clock);
         hold_run = pick_gap();
         if (hold_run > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_run) @(posedge clock);
         end
      end
   end

   initial begin
      int   sent;
      int   insert_pct;
      int   run_len;
      bit   no_gaps;
      logic op_kind;
      tracker   = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pop from empty, extreme and equal keys, fill up, overfill
      send_request(spq_pkg::KIND_POP, '1);
      send_request(spq_pkg::KIND_INSERT, '1);
      send_request(spq_pkg::KIND_INSERT, '0);
      send_request(spq_pkg::KIND_INSERT, 32'h8000_0000);
      send_request(spq_pkg::KIND_INSERT, 32'h8000_0000);
      send_request(spq_pkg::KIND_INSERT, 32'h7fff_ffff);
      send_request(spq_pkg::KIND_INSERT, '0);
      for (int i = 0; i < CAPACITY - 6; i++)
         send_request(spq_pkg::KIND_INSERT, pick_key());
      send_request(spq_pkg::KIND_INSERT, '0);
      send_request(spq_pkg::KIND_INSERT, '1);
      send_request(spq_pkg::KIND_POP, spq_pkg::KEY_W'($urandom));
      send_request(spq_pkg::KIND_POP, '0);

      // hold off until every result beat is back
      drain_results();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 50;
            default: insert_pct = 15;
         endcase
         run_len = $urandom_range(10, 60);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (run_len) begin
            if ($urandom_range(0, 99) < insert_pct)
               op_kind = spq_pkg::KIND_INSERT;
            else
               op_kind = spq_pkg::KIND_POP;
            send_request(op_kind, pick_key());
            sent++;
            if (!no_gaps)
               idle_requests(pick_gap());
         end
         if ($urandom_range(0, 7) == 0)
            drain_results();
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
